[rtl/core/sip_invite_client_txn_fsm_assert.svh]
// Assertion helpers used by the transaction output buffer.
`ifndef SIP_INVITE_CLIENT_TXN_FSM_ASSERT_SVH
`define SIP_INVITE_CLIENT_TXN_FSM_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SIP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sip txn assertion failed");

// Next-cycle implication, masked during reset.
`define SIP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sip txn assertion failed");

`endif

[rtl/core/sip_txn_pkg.sv]
package sip_txn_pkg;

   // Event codes
   localparam logic [2:0] EV_INVITE   = 3'd0;
   localparam logic [2:0] EV_TIMER_AB = 3'd1;
   localparam logic [2:0] EV_TIMER_D  = 3'd2;
   localparam logic [2:0] EV_1XX      = 3'd3;
   localparam logic [2:0] EV_2XX      = 3'd4;
   localparam logic [2:0] EV_FAIL     = 3'd5;
   localparam logic [2:0] EV_TERR     = 3'd6;

   // Timer commands
   localparam logic [1:0] TC_NONE = 2'd0;
   localparam logic [1:0] TC_A    = 2'd1;
   localparam logic [1:0] TC_B    = 2'd2;
   localparam logic [1:0] TC_D    = 2'd3;

   // Status codes
   localparam logic [2:0] SS_NONE   = 3'd0;
   localparam logic [2:0] SS_VALID  = 3'd1;
   localparam logic [2:0] SS_RETX   = 3'd2;
   localparam logic [2:0] SS_STRAY  = 3'd3;
   localparam logic [2:0] SS_IGNORE = 3'd4;
   localparam logic [2:0] SS_ERROR  = 3'd5;

   // Register indexes
   localparam logic [1:0] CSR_T1      = 2'd0;
   localparam logic [1:0] CSR_TIMER_B = 2'd1;
   localparam logic [1:0] CSR_TIMER_D = 2'd2;

   localparam logic [19:0] T1_RESET      = 20'd500;
   localparam logic [19:0] TIMER_B_RESET = 20'd32000;
   localparam logic [19:0] TIMER_D_RESET = 20'd32000;

   // Retransmission count where doubling stops, and count ceiling
   localparam logic [5:0] RETX_SAT_N = 6'd21;
   localparam logic [4:0] RETX_MAX   = 5'd31;

   typedef struct packed {
      logic [2:0]  command;
      logic        unreliable;
      logic        is_trying;
      logic        has_rseq;
      logic [31:0] rseq_value;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  new_state;
      logic [1:0]  timer_cmd;
      logic [19:0] timer_duration;
      logic        stop_timer;
      logic        send_ack;
      logic [2:0]  status;
      logic        txn_created;
      logic        txn_ended;
   } rsp_item_type;

   typedef struct packed {
      logic [19:0] t1_ms;
      logic [19:0] timer_b_ms;
      logic [19:0] timer_d_ms;
   } cfg_type;

endpackage

[rtl/core/sip_txn_step.sv]
module sip_txn_step
   import sip_txn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type req_data,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   typedef enum logic [2:0] {
      S_IDLE       = 3'd0,
      S_CALLING    = 3'd1,
      S_PROCEEDING = 3'd2,
      S_COMPLETED  = 3'd3,
      S_TERMINATED = 3'd4
   } fsm_state_type;

   fsm_state_type state_ff, state_in;
   logic          unrel_ff, unrel_in;
   logic [4:0]    retx_ff, retx_in;
   logic [19:0]   elapsed_ff, elapsed_in;
   logic [19:0]   limit_ff, limit_in;
   logic [31:0]   rseq_ff, rseq_in;
   logic          known_ff, known_in;

   // Timer A retransmission math
   logic [19:0] expired;
   logic [5:0]  retx_n;
   logic [39:0] t1_shift;
   logic [19:0] remain;
   logic        use_remain;
   logic [19:0] retx_dur;
   logic        timed_out;

   always_comb begin
      expired    = (elapsed_ff == 20'd0) ? cfg.t1_ms : elapsed_ff;
      retx_n     = {1'b0, retx_ff} + 6'd1;
      t1_shift   = {20'd0, cfg.t1_ms} << retx_n[4:0];
      remain     = limit_ff - expired;
      use_remain = (retx_n >= RETX_SAT_N) || (t1_shift[39:20] != 20'd0) ||
                   (t1_shift[19:0] >= remain);
      retx_dur   = use_remain ? remain : t1_shift[19:0];
      timed_out  = !unrel_ff || (expired >= limit_ff);
   end

   // Event decode per state
   always_comb begin
      logic ok;
      ok         = 1'b1;
      state_in   = state_ff;
      unrel_in   = unrel_ff;
      retx_in    = retx_ff;
      elapsed_in = elapsed_ff;
      limit_in   = limit_ff;
      rseq_in    = rseq_ff;
      known_in   = known_ff;
      result     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_data.command == EV_INVITE) begin
               unrel_in   = req_data.unreliable;
               retx_in    = 5'd0;
               elapsed_in = 20'd0;
               known_in   = 1'b0;
               rseq_in    = 32'd0;
               limit_in   = cfg.timer_b_ms;
               if (req_data.unreliable) begin
                  result.timer_cmd      = TC_A;
                  result.timer_duration = cfg.t1_ms;
               end else begin
                  result.timer_cmd      = TC_B;
                  result.timer_duration = cfg.timer_b_ms;
               end
               result.txn_created = 1'b1;
               state_in           = S_CALLING;
            end else begin
               ok = 1'b0;
            end
         end
         S_CALLING: begin
            case (req_data.command)
               EV_TIMER_AB: begin
                  elapsed_in = expired;
                  if (timed_out) begin
                     state_in = S_TERMINATED;
                  end else if (retx_dur != 20'd0) begin
                     result.timer_cmd      = TC_A;
                     result.timer_duration = retx_dur;
                     retx_in    = (retx_ff == RETX_MAX) ? retx_ff : retx_ff + 5'd1;
                     elapsed_in = expired + retx_dur;
                  end
               end
               EV_1XX: begin
                  result.stop_timer = 1'b1;
                  result.status     = SS_VALID;
                  if (!req_data.is_trying && req_data.has_rseq) begin
                     rseq_in  = req_data.rseq_value;
                     known_in = 1'b1;
                  end
                  state_in = S_PROCEEDING;
               end
               EV_2XX: begin
                  result.stop_timer = 1'b1;
                  result.status     = SS_VALID;
                  result.txn_ended  = 1'b1;
                  state_in          = S_TERMINATED;
               end
               EV_FAIL: begin
                  result.stop_timer = 1'b1;
                  result.send_ack   = 1'b1;
                  result.status     = SS_VALID;
                  if (unrel_ff) begin
                     result.timer_cmd      = TC_D;
                     result.timer_duration = cfg.timer_d_ms;
                     state_in              = S_COMPLETED;
                  end else begin
                     result.txn_ended = 1'b1;
                     state_in         = S_TERMINATED;
                  end
               end
               EV_TERR: begin
                  result.stop_timer = 1'b1;
                  state_in          = S_TERMINATED;
               end
               default: ok = 1'b0;
            endcase
         end
         S_PROCEEDING: begin
            case (req_data.command)
               EV_1XX: begin
                  result.status = SS_VALID;
                  if (!req_data.is_trying && req_data.has_rseq) begin
                     if (known_ff && rseq_ff == req_data.rseq_value) begin
                        result.status = SS_RETX;
                     end else if (known_ff) begin
                        if (rseq_ff + 32'd1 != req_data.rseq_value) begin
                           result.status = SS_STRAY;
                        end else begin
                           rseq_in = req_data.rseq_value;
                        end
                     end else begin
                        rseq_in  = req_data.rseq_value;
                        known_in = 1'b1;
                     end
                  end
               end
               EV_2XX: begin
                  known_in         = 1'b0;
                  result.status    = SS_VALID;
                  result.txn_ended = 1'b1;
                  state_in         = S_TERMINATED;
               end
               EV_FAIL: begin
                  known_in        = 1'b0;
                  result.send_ack = 1'b1;
                  result.status   = SS_VALID;
                  if (unrel_ff) begin
                     result.timer_cmd      = TC_D;
                     result.timer_duration = cfg.timer_d_ms;
                     state_in              = S_COMPLETED;
                  end else begin
                     result.txn_ended = 1'b1;
                     state_in         = S_TERMINATED;
                  end
               end
               EV_TERR: state_in = S_TERMINATED;
               default: ok = 1'b0;
            endcase
         end
         S_COMPLETED: begin
            case (req_data.command)
               EV_TIMER_D: state_in = S_TERMINATED;
               EV_1XX:     result.status = SS_IGNORE;
               EV_FAIL: begin
                  result.status   = SS_RETX;
                  result.send_ack = 1'b1;
               end
               EV_TERR: begin
                  result.stop_timer = 1'b1;
                  state_in          = S_TERMINATED;
               end
               default: ok = 1'b0;
            endcase
         end
         default: ok = 1'b0;
      endcase

      // rejected event: nothing moves, only the error status
      if (!ok) begin
         result        = '0;
         result.status = SS_ERROR;
      end
      result.new_state = state_in;
   end

   // Transaction state, updated on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         unrel_ff   <= 1'b0;
         retx_ff    <= 5'd0;
         elapsed_ff <= 20'd0;
         limit_ff   <= 20'd0;
         rseq_ff    <= 32'd0;
         known_ff   <= 1'b0;
      end else if (accept) begin
         state_ff   <= state_in;
         unrel_ff   <= unrel_in;
         retx_ff    <= retx_in;
         elapsed_ff <= elapsed_in;
         limit_ff   <= limit_in;
         rseq_ff    <= rseq_in;
         known_ff   <= known_in;
      end
   end

endmodule

[rtl/core/sip_txn_obuf.sv]
`include "sip_invite_client_txn_fsm_assert.svh"

module sip_txn_obuf
   import sip_txn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic         out_vld_ff;
   logic         skid_vld_ff;
   rsp_item_type out_ff;
   rsp_item_type skid_ff;
   logic         pop;

   assign pop       = out_vld_ff && !rsp_stall;
   assign full      = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Valid flags: output stage plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         out_vld_ff <= 1'b0;
      end
   end

   // Payload moves, no reset needed
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            out_ff <= push_data;
         end
      end
   end

   `SIP_ASSERT_IMP(a_skid_needs_out, clock, reset, skid_vld_ff, out_vld_ff)
   `SIP_ASSERT_NXT(a_stall_fills_skid, clock, reset, push && out_vld_ff && rsp_stall, skid_vld_ff)
   `SIP_ASSERT_NXT(a_skid_drains, clock, reset, skid_vld_ff && !rsp_stall, out_vld_ff && !skid_vld_ff)
   `SIP_ASSERT_NXT(a_empty_push, clock, reset, push && !out_vld_ff, out_vld_ff && !skid_vld_ff)

endmodule

[rtl/core/sip_invite_client_txn_fsm.sv]
// Channel  Direction  Handshake           Beat
// req_     in         req_valid/stall     req_item_type: one event
// rsp_     out        rsp_valid/stall     rsp_item_type: one result per event
// csr_     in         csr_valid/ready     csr_index, csr_wdata (20 bits)
//
// One event per cycle while req_stall is low; its result is registered in the output buffer.
// The state update is a single combinational step between the state and
// output registers; a one-entry skid buffer keeps req_ open while rsp_ stalls.
// req_stall rises only once both output entries are full.
// reset is synchronous: state goes idle, registers take their defaults.
module sip_invite_client_txn_fsm
   import sip_txn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   cfg_type      cfg_ff;
   rsp_item_type step_result;
   logic         accept;
   logic         buf_full;

   assign csr_ready = 1'b1;
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.t1_ms      <= T1_RESET;
         cfg_ff.timer_b_ms <= TIMER_B_RESET;
         cfg_ff.timer_d_ms <= TIMER_D_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_T1:      cfg_ff.t1_ms      <= csr_wdata;
            CSR_TIMER_B: cfg_ff.timer_b_ms <= csr_wdata;
            CSR_TIMER_D: cfg_ff.timer_d_ms <= csr_wdata;
            default:     ;
         endcase
      end
   end

   sip_txn_step u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .result   (step_result)
   );

   sip_txn_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/tb.sv]
module tb
   import sip_txn_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Transaction states as reported in new_state
   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_CALLING    = 3'd1;
   localparam logic [2:0] S_PROCEEDING = 3'd2;
   localparam logic [2:0] S_COMPLETED  = 3'd3;
   localparam logic [2:0] S_TERMINATED = 3'd4;

   // Command code with no meaning; always rejected
   localparam logic [2:0] EV_UNUSED = 3'd7;

   localparam logic [19:0] MS_MAX         = 20'hFFFFF;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          HOLD_CYCLES    = 60;
   localparam int          WATCHDOG_LIMIT = 1000;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [19:0]  csr_wdata;

   // Predicted transaction state and register copies
   logic [2:0]  txn_state;
   logic        over_udp;
   logic [4:0]  resend_count;
   logic [19:0] time_spent;
   logic [19:0] time_cap;
   logic [31:0] rseq_last;
   logic        rseq_held;
   logic [19:0] cfg_t1;
   logic [19:0] cfg_timer_b;
   logic [19:0] cfg_timer_d;

   rsp_item_type pending_results[$];
   rsp_item_type want;

   int failures       = 0;
   int events_sent    = 0;
   int results_seen   = 0;
   int reg_writes     = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int idle_cycles    = 0;
   int hold_count     = 0;
   bit hold_armed     = 1'b0;

   sip_invite_client_txn_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Final response handling shared by calling and proceeding
   function automatic void final_failure(inout rsp_item_type r);
      r.send_ack = 1'b1;
      r.status   = SS_VALID;
      if (over_udp) begin
         r.timer_cmd      = TC_D;
         r.timer_duration = cfg_timer_d;
         txn_state        = S_COMPLETED;
      end else begin
         r.txn_ended = 1'b1;
         txn_state   = S_TERMINATED;
      end
   endfunction

   // Timer A/B expiry in calling: back off, cap at the limit, or give up
   function automatic void timer_expiry(inout rsp_item_type r);
      logic [19:0] expired;
      logic [19:0] remain;
      logic [5:0]  n;
      logic [63:0] dur;
      if (time_spent == '0)
         time_spent = cfg_t1;
      expired = time_spent;
      if (!over_udp || expired >= time_cap) begin
         txn_state = S_TERMINATED;
      end else begin
         n      = {1'b0, resend_count} + 6'd1;
         remain = time_cap - expired;
         if (n >= RETX_SAT_N)
            dur = 64'(remain);
         else
            dur = 64'(cfg_t1) << n;
         if (64'(expired) + dur >= 64'(time_cap))
            dur = 64'(remain);
         if (dur != '0) begin
            r.timer_cmd      = TC_A;
            r.timer_duration = dur[19:0];
            if (resend_count != RETX_MAX)
               resend_count = resend_count + 5'd1;
            time_spent = time_spent + dur[19:0];
         end
      end
   endfunction

   // Advance the predicted state by one event and return its result
   function automatic rsp_item_type next_result(req_item_type ev);
      rsp_item_type r;
      logic         taken;
      r     = '0;
      taken = 1'b1;
      case (txn_state)
         S_IDLE: begin
            if (ev.command == EV_INVITE) begin
               over_udp     = ev.unreliable;
               resend_count = '0;
               time_spent   = '0;
               rseq_held    = 1'b0;
               rseq_last    = '0;
               time_cap     = cfg_timer_b;
               if (ev.unreliable) begin
                  r.timer_cmd      = TC_A;
                  r.timer_duration = cfg_t1;
               end else begin
                  r.timer_cmd      = TC_B;
                  r.timer_duration = cfg_timer_b;
               end
               r.txn_created = 1'b1;
               txn_state     = S_CALLING;
            end else
               taken = 1'b0;
         end
         S_CALLING: begin
            case (ev.command)
               EV_TIMER_AB: timer_expiry(r);
               EV_1XX: begin
                  r.stop_timer = 1'b1;
                  r.status     = SS_VALID;
                  if (!ev.is_trying && ev.has_rseq) begin
                     rseq_last = ev.rseq_value;
                     rseq_held = 1'b1;
                  end
                  txn_state = S_PROCEEDING;
               end
               EV_2XX: begin
                  r.stop_timer = 1'b1;
                  r.status     = SS_VALID;
                  r.txn_ended  = 1'b1;
                  txn_state    = S_TERMINATED;
               end
               EV_FAIL: begin
                  r.stop_timer = 1'b1;
                  final_failure(r);
               end
               EV_TERR: begin
                  r.stop_timer = 1'b1;
                  txn_state    = S_TERMINATED;
               end
               default: taken = 1'b0;
            endcase
         end
         S_PROCEEDING: begin
            case (ev.command)
               EV_1XX: begin
                  r.status = SS_VALID;
                  // reliable provisional: RSeq must repeat or advance by one
                  if (!ev.is_trying && ev.has_rseq) begin
                     if (rseq_held && rseq_last == ev.rseq_value)
                        r.status = SS_RETX;
                     else if (rseq_held && rseq_last + 32'd1 != ev.rseq_value)
                        r.status = SS_STRAY;
                     else begin
                        rseq_last = ev.rseq_value;
                        rseq_held = 1'b1;
                     end
                  end
               end
               EV_2XX: begin
                  rseq_held   = 1'b0;
                  r.status    = SS_VALID;
                  r.txn_ended = 1'b1;
                  txn_state   = S_TERMINATED;
               end
               EV_FAIL: begin
                  rseq_held = 1'b0;
                  final_failure(r);
               end
               EV_TERR: txn_state = S_TERMINATED;
               default: taken = 1'b0;
            endcase
         end
         S_COMPLETED: begin
            case (ev.command)
               EV_TIMER_D: txn_state = S_TERMINATED;
               EV_1XX:     r.status = SS_IGNORE;
               EV_FAIL: begin
                  r.status   = SS_RETX;
                  r.send_ack = 1'b1;
               end
               EV_TERR: begin
                  r.stop_timer = 1'b1;
                  txn_state    = S_TERMINATED;
               end
               default: taken = 1'b0;
            endcase
         end
         default: taken = 1'b0;
      endcase
      if (!taken) begin
         r        = '0;
         r.status = SS_ERROR;
      end
      r.new_state = txn_state;
      return r;
   endfunction

   // True when the command would move the transaction out of its state
   function automatic bit leaves_state(logic [2:0] cmd);
      logic [19:0] first_expiry;
      first_expiry = (time_spent == '0) ? cfg_t1 : time_spent;
      case (txn_state)
         S_IDLE:       return cmd == EV_INVITE;
         S_CALLING: begin
            if (cmd == EV_TIMER_AB)
               return !over_udp || first_expiry >= time_cap;
            return cmd == EV_1XX || cmd == EV_2XX || cmd == EV_FAIL || cmd == EV_TERR;
         end
         S_PROCEEDING: return cmd == EV_2XX || cmd == EV_FAIL || cmd == EV_TERR;
         S_COMPLETED:  return cmd == EV_TIMER_D || cmd == EV_TERR;
         default:      return 1'b0;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_val,
                                       logic [31:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         failures++;
      end
   endfunction

   // Offer one event beat, with a random gap ahead of it
   task automatic send_event(input req_item_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = ev;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_results.push_back(next_result(ev));
      events_sent++;
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [2:0] cmd, input logic unrel, input logic trying,
                              input logic has, input logic [31:0] rseq);
      req_item_type ev;
      ev.command    = cmd;
      ev.unreliable = unrel;
      ev.is_trying  = trying;
      ev.has_rseq   = has;
      ev.rseq_value = rseq;
      send_event(ev);
   endtask

   // Random events that keep the current state, except a favored command
   // that is taken when it does not end the state
   task automatic send_mixed(input int count, input logic [2:0] favored,
                             input int favored_pct);
      req_item_type ev;
      logic [2:0]   cmd;
      repeat (count) begin
         cmd = favored;
         if ($urandom_range(99) >= favored_pct || leaves_state(cmd)) begin
            do
               cmd = 3'($urandom_range(7));
            while (leaves_state(cmd));
         end
         ev.command    = cmd;
         ev.unreliable = 1'($urandom_range(1));
         ev.is_trying  = 1'($urandom_range(1));
         ev.has_rseq   = 1'($urandom_range(1));
         case ($urandom_range(3))
            0:       ev.rseq_value = rseq_last;
            1:       ev.rseq_value = rseq_last + 32'd1;
            default: ev.rseq_value = $urandom;
         endcase
         send_event(ev);
      end
   endtask

   // Stop offering and let every outstanding result come back
   task automatic wait_quiet();
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_T1:      cfg_t1 = value;
         CSR_TIMER_B: cfg_timer_b = value;
         CSR_TIMER_D: cfg_timer_d = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Every command other than invite is refused in idle
   task automatic test_idle_rejects();
      logic [2:0] cmds[7];
      cmds = '{EV_TIMER_AB, EV_TIMER_D, EV_1XX, EV_2XX, EV_FAIL, EV_TERR, EV_UNUSED};
      foreach (cmds[i])
         send_fields(cmds[i], i[0], i[1], i[2], i[0] ? '1 : '0);
      wait_quiet();
   endtask

   // Invite over UDP at the largest T1 and limit, then refused commands
   task automatic test_invite();
      write_reg(CSR_T1, MS_MAX);
      write_reg(CSR_TIMER_B, MS_MAX);
      write_reg(CSR_TIMER_D, '0);
      send_fields(EV_INVITE, 1'b1, 1'b1, 1'b1, '1);
      send_fields(EV_INVITE, 1'b0, 1'b0, 1'b0, '0);
      send_fields(EV_TIMER_D, 1'b1, 1'b0, 1'b1, '1);
      send_fields(EV_UNUSED, 1'b0, 1'b1, 1'b0, '0);
      wait_quiet();
   endtask

   // Timer A doubling from T1 = 1 up to the cap, with refused commands mixed in
   task automatic test_timer_a_backoff();
      write_reg(CSR_T1, 20'd1);
      send_idle_pct = 56;
      send_mixed(150, EV_TIMER_AB, 50);
      wait_quiet();
      send_idle_pct = 0;
   endtask

   // Provisional responses and RSeq tracking, including wrap and a long stall
   task automatic test_provisional_rseq();
      write_reg(CSR_TIMER_B, 20'd1);
      write_reg(CSR_TIMER_D, MS_MAX);
      write_reg(CSR_T1, 20'($urandom_range(MS_MAX, 1)));
      send_fields(EV_1XX, 1'b0, 1'b0, 1'b1, '1);
      send_fields(EV_1XX, 1'b1, 1'b0, 1'b1, '0);
      send_fields(EV_1XX, 1'b0, 1'b0, 1'b1, '0);
      send_fields(EV_1XX, 1'b0, 1'b0, 1'b1, 32'd5);
      send_fields(EV_1XX, 1'b0, 1'b1, 1'b1, 32'd9);
      send_fields(EV_1XX, 1'b0, 1'b0, 1'b0, 32'd9);
      send_fields(EV_TIMER_AB, 1'b1, 1'b1, 1'b1, '1);
      wait_quiet();
      stall_pct  = 56;
      hold_armed = 1'b1;
      send_mixed(250, EV_1XX, 60);
      wait_quiet();
      stall_pct = 0;
   endtask

   // Failure response over UDP starts timer D; retransmissions get an ACK
   task automatic test_completed();
      write_reg(CSR_TIMER_D, 20'($urandom_range(MS_MAX, 0)));
      send_idle_pct = 15;
      stall_pct     = 15;
      send_fields(EV_FAIL, 1'b0, 1'($urandom_range(1)), 1'b1, $urandom);
      send_mixed(150, EV_FAIL, 30);
      wait_quiet();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // Timer D ends the transaction; everything after is refused
   task automatic test_terminated();
      write_reg(CSR_T1, 20'($urandom_range(MS_MAX, 1)));
      write_reg(CSR_TIMER_B, 20'($urandom_range(MS_MAX, 1)));
      write_reg(CSR_TIMER_D, 20'($urandom_range(MS_MAX, 0)));
      send_fields(EV_TIMER_D, 1'b0, 1'b0, 1'b0, '0);
      send_mixed(200, EV_UNUSED, 0);
      wait_quiet();
   endtask

   // Receiver: random stalls, plus one long hold-off once armed
   always @(negedge clock) begin
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_stall = 1'b1;
         hold_count++;
      end else
         rsp_stall = ($urandom_range(99) < stall_pct);
   end

   // Compare each result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: %p", rsp_data);
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("new_state", 32'(want.new_state), 32'(rsp_data.new_state));
            check_field("timer_cmd", 32'(want.timer_cmd), 32'(rsp_data.timer_cmd));
            check_field("timer_duration", 32'(want.timer_duration),
                        32'(rsp_data.timer_duration));
            check_field("stop_timer", 32'(want.stop_timer), 32'(rsp_data.stop_timer));
            check_field("send_ack", 32'(want.send_ack), 32'(rsp_data.send_ack));
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("txn_created", 32'(want.txn_created), 32'(rsp_data.txn_created));
            check_field("txn_ended", 32'(want.txn_ended), 32'(rsp_data.txn_ended));
         end
      end
   end

   // Watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_T1;
      csr_wdata    = '0;
      txn_state    = S_IDLE;
      over_udp     = 1'b0;
      resend_count = '0;
      time_spent   = '0;
      time_cap     = '0;
      rseq_last    = '0;
      rseq_held    = 1'b0;
      cfg_t1       = T1_RESET;
      cfg_timer_b  = TIMER_B_RESET;
      cfg_timer_d  = TIMER_D_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_rejects();
      test_invite();
      test_timer_a_backoff();
      test_provisional_rseq();
      test_completed();
      test_terminated();

      $display("Run: %0d events through idle, calling, proceeding, completed, terminated;",
               events_sent);
      $display("     %0d results compared, %0d register writes.", results_seen, reg_writes);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sip_txn_pkg.sv
rtl/core/sip_txn_step.sv
rtl/core/sip_txn_obuf.sv
rtl/core/sip_invite_client_txn_fsm.sv
tb/tb.sv
